### hw/rtl/multi_waveform_phase_oscillator_core_macros.svh
// assertion helpers for the oscillator checker
// both expect clk and arst_n to be visible where they are used
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_CORE_MACROS_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_CORE_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define MWPO_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("oscillator check failed");

// consequent must hold in the same cycle as the antecedent
`define MWPO_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("oscillator check failed");

`endif

### hw/rtl/mwpo_pkg.sv
`timescale 1ns / 1ps

package mwpo_pkg;

	// field widths
	localparam int unsigned MODE_W = 3;
	localparam int unsigned FREQ_W = 24;
	localparam int unsigned PSET_W = 32;
	localparam int unsigned SR_W   = 19;
	localparam int unsigned SMP_W  = 16;
	localparam int unsigned ROM_W  = 15;

	// waveform codes
	localparam logic [MODE_W-1:0] MODE_PHASOR   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SINE     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SQUARE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SAWTOOTH = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TRIANGLE = 3'd4;

	localparam logic [SR_W-1:0] SR_RESET = 19'd48000;

	// full-scale sample limits in q1.15
	localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
	localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

	// quarter-wave table constants, q2.30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1 << 30;
	localparam longint unsigned ROUND_Q15   = 64'd1 << 14;
	localparam longint unsigned ROM_MAX     = 64'd32767;

	// channel payloads
	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [FREQ_W-1:0] frequency;
		logic [PSET_W-1:0]        phase_setting;
	} req_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
	} res_t;

	typedef struct packed {
		logic [SR_W-1:0] sample_rate;
	} cfg_t;

	// sequencer to phase accumulator
	typedef struct packed {
		logic reload;
		logic carry_init;
		logic step;
	} phase_ctl_t;

	// sequencer to divider
	typedef struct packed {
		logic start;
		logic rotate;
	} div_ctl_t;

	// divider back to sequencer and accumulator
	typedef struct packed {
		logic busy;
		logic inc_bit;
		logic neg;
	} div_sts_t;

	// one quarter-wave entry, taylor series in horner form, evaluated at elaboration
	function automatic logic [ROM_W-1:0] sine_entry(input longint unsigned k,
			input int unsigned bits);
		longint unsigned a;
		longint unsigned a2;
		longint unsigned u;
		longint unsigned s;
		a  = (k * HALF_PI_Q30) >> bits;
		a2 = (a * a) >> 30;
		u  = ONE_Q30 - a2 / 72;
		u  = ONE_Q30 - ((a2 * u) >> 30) / 42;
		u  = ONE_Q30 - ((a2 * u) >> 30) / 20;
		u  = ONE_Q30 - ((a2 * u) >> 30) / 6;
		s  = (a * u) >> 30;
		s  = (s + ROUND_Q15) >> 15;
		if (s > ROM_MAX) begin
			s = ROM_MAX;
		end
		return s[ROM_W-1:0];
	endfunction

endpackage

### hw/rtl/mwpo_stream_if.sv
`timescale 1ns / 1ps

// valid/ready channel with a typed payload
interface mwpo_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/mwpo_div.sv
`timescale 1ns / 1ps

// bit-serial restoring divider: |frequency| * 2^(PHASE_BITS-8) / sample_rate,
// one quotient bit per cycle, msb first; the low PHASE_BITS quotient bits are
// kept as the increment magnitude and later rotated out lsb first
module mwpo_div import mwpo_pkg::*; #(
	parameter int unsigned PHASE_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  div_ctl_t                 ctl,
	input  logic signed [FREQ_W-1:0] frequency,
	input  logic [SR_W-1:0]          sample_rate,
	output div_sts_t                 sts
);

	localparam int unsigned DIV_STEPS = PHASE_BITS + 16;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [FREQ_W-1:0]     dvd_q;
	logic [SR_W-1:0]       rem_q;
	logic [PHASE_BITS-1:0] inc_q;
	logic                  neg_q;

	logic [FREQ_W-1:0] freq_u;
	logic [FREQ_W-1:0] mag;
	logic [SR_W:0]     trial;
	logic [SR_W:0]     diff;
	logic              ge;

	// magnitude of the frequency; the most negative value maps to itself
	assign freq_u = frequency;
	assign mag    = freq_u[FREQ_W-1] ? (~freq_u + 24'd1) : freq_u;

	// one trial subtraction; a zero divisor yields a zero quotient
	assign trial = {rem_q, dvd_q[FREQ_W-1]};
	assign diff  = trial - {1'b0, sample_rate};
	assign ge    = (sample_rate != '0) && (trial >= {1'b0, sample_rate});

	// control and increment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			inc_q  <= '0;
			neg_q  <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			neg_q  <= freq_u[FREQ_W-1];
		end else if (busy_q) begin
			inc_q <= {inc_q[PHASE_BITS-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end else if (ctl.rotate) begin
			inc_q <= {inc_q[0], inc_q[PHASE_BITS-1:1]};
		end
	end

	// dividend and partial remainder
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= mag;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[FREQ_W-2:0], 1'b0};
			rem_q <= ge ? diff[SR_W-1:0] : trial[SR_W-1:0];
		end
	end

	// negative increments are added as inverted bits plus a carry in
	assign sts.busy    = busy_q;
	assign sts.inc_bit = inc_q[0] ^ neg_q;
	assign sts.neg     = neg_q;

endmodule

### hw/rtl/mwpo_phase.sv
`timescale 1ns / 1ps

// phase accumulator: parallel reload from the phase setting, bit-serial add
module mwpo_phase import mwpo_pkg::*; #(
	parameter int unsigned PHASE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  phase_ctl_t            ctl,
	input  logic [PSET_W-1:0]     setting,
	input  logic                  inc_bit,
	input  logic                  carry_in,
	output logic [PHASE_BITS-1:0] phase
);

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] mapped;
	logic                  carry_q;
	logic                  sum_bit;
	logic                  carry_nxt;

	// setting is a q0.32 fraction; align it to the accumulator width
	generate
		if (PHASE_BITS >= PSET_W) begin : g_widen
			assign mapped = PHASE_BITS'(setting) << (PHASE_BITS - PSET_W);
		end else begin : g_narrow
			assign mapped = PHASE_BITS'(setting >> (PSET_W - PHASE_BITS));
		end
	endgenerate

	// full adder on the lsb
	assign sum_bit   = phase_q[0] ^ inc_bit ^ carry_q;
	assign carry_nxt = (phase_q[0] & inc_bit) | (carry_q & (phase_q[0] ^ inc_bit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			carry_q <= 1'b0;
		end else begin
			if (ctl.reload) begin
				phase_q <= mapped;
			end else if (ctl.step) begin
				phase_q <= {sum_bit, phase_q[PHASE_BITS-1:1]};
			end
			if (ctl.carry_init) begin
				carry_q <= carry_in;
			end else if (ctl.step) begin
				carry_q <= carry_nxt;
			end
		end
	end

	assign phase = phase_q;

endmodule

### hw/rtl/mwpo_wave.sv
`timescale 1ns / 1ps

// waveform shaper: quarter-wave rom read plus the simple shapes
module mwpo_wave import mwpo_pkg::*; #(
	parameter int unsigned PHASE_BITS      = 32,
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [MODE_W-1:0]       mode,
	input  logic [PHASE_BITS-1:0]   phase,
	output logic signed [SMP_W-1:0] sample
);

	localparam int unsigned QUARTER = 1 << SINE_TABLE_BITS;
	localparam int unsigned IDX_W   = SINE_TABLE_BITS + 1;
	localparam int unsigned PAD_W   = PHASE_BITS - 2 + SINE_TABLE_BITS;

	logic [ROM_W-1:0] rom_w [0:QUARTER];

	logic [1:0]                 quad;
	logic [PAD_W-1:0]           padded;
	logic [SINE_TABLE_BITS-1:0] fine_idx;
	logic [IDX_W-1:0]           idx;

	logic [ROM_W-1:0]  rom_s1;
	logic [SMP_W-1:0]  t_s1;
	logic [MODE_W-1:0] mode_s1;
	logic              neg_s1;

	logic [SMP_W-1:0]   sin_pos;
	logic [SMP_W-1:0]   sin_val;
	logic [SMP_W:0]     tri_abs;
	logic [SMP_W-1:0]   tri_val;

	// quarter-wave table, one entry past the quarter point
	generate
		for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
			localparam logic [ROM_W-1:0] ENTRY =
				sine_entry(longint'(k), SINE_TABLE_BITS);
			assign rom_w[k] = ENTRY;
		end
	endgenerate

	// quadrant and table index, mirrored in odd quadrants
	assign quad     = phase[PHASE_BITS-1 -: 2];
	assign padded   = {phase[PHASE_BITS-3:0], {SINE_TABLE_BITS{1'b0}}};
	assign fine_idx = padded[PAD_W-1 -: SINE_TABLE_BITS];
	assign idx      = quad[0] ? (IDX_W'(QUARTER) - {1'b0, fine_idx}) : {1'b0, fine_idx};

	// rom read and operand capture
	always_ff @(posedge clk) begin
		if (en) begin
			rom_s1  <= rom_w[idx];
			t_s1    <= phase[PHASE_BITS-1 -: SMP_W];
			mode_s1 <= mode;
			neg_s1  <= quad[1];
		end
	end

	// sine sign from the top phase bit: negative in the second half of the cycle
	assign sin_pos = {1'b0, rom_s1};
	assign sin_val = neg_s1 ? (~sin_pos + 16'd1) : sin_pos;

	// triangle: distance from mid cycle, doubled and re-centred
	assign tri_abs = t_s1[SMP_W-1] ? {2'b00, t_s1[SMP_W-2:0]}
	                               : (17'd32768 - {1'b0, t_s1});
	assign tri_val = tri_abs[SMP_W-1] ? SMP_MAX
	                                  : {~tri_abs[SMP_W-2], tri_abs[SMP_W-3:0], 1'b0};

	// shape select
	always_comb begin
		case (mode_s1)
			MODE_PHASOR:   sample = {1'b0, t_s1[SMP_W-1:1]};
			MODE_SINE:     sample = sin_val;
			MODE_SQUARE:   sample = t_s1[SMP_W-1] ? SMP_MIN : SMP_MAX;
			MODE_SAWTOOTH: sample = {~t_s1[SMP_W-1], t_s1[SMP_W-2:0]};
			MODE_TRIANGLE: sample = tri_val;
			default:       sample = '0;
		endcase
	end

endmodule

### hw/rtl/multi_waveform_phase_oscillator_core.sv
`timescale 1ns / 1ps

// multi-waveform phase oscillator (direct digital synthesis)
// req_ch takes one sample request: mode, frequency (1/256 Hz) and phase setting.
// res_ch returns one q1.15 sample per request, formed from the phase before the
// step. cfg_ch writes sample_rate; write it only while no request is in flight.
// a changed phase setting reloads the accumulator before the sample is formed;
// a changed frequency starts the bit-serial divider for a new increment.
// on acceptance the sequencer passes through S_WAVE, where the shaper captures
// its rom read, then S_SAMPLE, where the output register is loaded once free.
// a new request is taken only after the bit-serial phase add has finished; when
// the frequency changes, the divider must first finish the new increment.
// the result sits in an output register: if the receiver stalls, the next
// request is still accepted and runs up to the point where its sample would
// be loaded, then waits for the register to drain.
// reset clears the phase, last setting, last frequency and increment to zero
// and sets sample_rate to 48000; the quarter-wave table is a constant rom.
module multi_waveform_phase_oscillator_core import mwpo_pkg::*; #(
	parameter int unsigned SINE_TABLE_BITS = 10,
	parameter int unsigned PHASE_BITS      = 32
) (
	input logic          clk,
	input logic          arst_n,
	mwpo_stream_if.sink   req_ch,
	mwpo_stream_if.source res_ch,
	mwpo_stream_if.sink   cfg_ch
);

	localparam int unsigned ADD_W = $clog2(PHASE_BITS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_WAVE   = 3'd1;
	localparam logic [2:0] S_SAMPLE = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_ADD    = 3'd4;

	logic [2:0]               state_q;
	logic [ADD_W-1:0]         add_cnt_q;
	logic [PSET_W-1:0]        last_pset_q;
	logic signed [FREQ_W-1:0] last_freq_q;
	logic [SR_W-1:0]          sr_q;
	logic [MODE_W-1:0]        mode_q;
	logic signed [FREQ_W-1:0] freq_q;
	logic                     out_valid_q;
	logic signed [SMP_W-1:0]  out_sample_q;

	logic                    req_take;
	logic                    out_load;
	logic                    wave_en;
	logic signed [SMP_W-1:0] wave_sample;
	logic [PHASE_BITS-1:0]   phase;
	phase_ctl_t              phase_ctl;
	div_ctl_t                div_ctl;
	div_sts_t                div_sts;

	// handshakes
	assign req_ch.ready = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign req_take     = req_ch.valid && req_ch.ready;

	// sequencer outputs
	always_comb begin
		phase_ctl.reload     = req_take && (req_ch.data.phase_setting != last_pset_q);
		phase_ctl.carry_init = (state_q == S_DIV) && !div_sts.busy;
		phase_ctl.step       = (state_q == S_ADD);
		div_ctl.start        = (state_q == S_WAVE) && (freq_q != last_freq_q);
		div_ctl.rotate       = (state_q == S_ADD);
		wave_en              = (state_q == S_WAVE);
		out_load             = (state_q == S_SAMPLE) && (!out_valid_q || res_ch.ready);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			add_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						state_q <= S_WAVE;
					end
				end
				S_WAVE: begin
					state_q <= S_SAMPLE;
				end
				S_SAMPLE: begin
					if (out_load) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!div_sts.busy) begin
						add_cnt_q <= '0;
						state_q   <= S_ADD;
					end
				end
				S_ADD: begin
					add_cnt_q <= add_cnt_q + 1'b1;
					if (add_cnt_q == ADD_W'(PHASE_BITS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// last-seen settings and the sample rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pset_q <= '0;
			last_freq_q <= '0;
			sr_q        <= SR_RESET;
		end else begin
			if (phase_ctl.reload) begin
				last_pset_q <= req_ch.data.phase_setting;
			end
			if (div_ctl.start) begin
				last_freq_q <= freq_q;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				sr_q <= cfg_ch.data.sample_rate;
			end
		end
	end

	// request fields held for the rest of the step
	always_ff @(posedge clk) begin
		if (req_take) begin
			mode_q <= req_ch.data.mode;
			freq_q <= req_ch.data.frequency;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= wave_sample;
		end
	end

	assign res_ch.valid       = out_valid_q;
	assign res_ch.data.sample = out_sample_q;

	// datapath units
	mwpo_phase #(
		.PHASE_BITS (PHASE_BITS)
	) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (phase_ctl),
		.setting  (req_ch.data.phase_setting),
		.inc_bit  (div_sts.inc_bit),
		.carry_in (div_sts.neg),
		.phase    (phase)
	);

	mwpo_div #(
		.PHASE_BITS (PHASE_BITS)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (div_ctl),
		.frequency   (freq_q),
		.sample_rate (sr_q),
		.sts         (div_sts)
	);

	mwpo_wave #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_wave (
		.clk    (clk),
		.en     (wave_en),
		.mode   (mode_q),
		.phase  (phase),
		.sample (wave_sample)
	);

endmodule

### hw/rtl/mwpo_chk.sv
`timescale 1ns / 1ps
`include "multi_waveform_phase_oscillator_core_macros.svh"

// port-level checks on the oscillator
module mwpo_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] res_sample
);

	// a held result stays offered
	`MWPO_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

	// a held result keeps its value
	`MWPO_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_sample))

	// one request at a time: the core is busy right after taking one
	`MWPO_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

	// a new sample appears while its request still holds the core busy
	`MWPO_ASSERT_SAME(a_sample_busy, $rose(res_valid), !req_ready)

endmodule

bind multi_waveform_phase_oscillator_core mwpo_chk u_mwpo_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_ch.valid),
	.req_ready  (req_ch.ready),
	.res_valid  (res_ch.valid),
	.res_ready  (res_ch.ready),
	.res_sample (res_ch.data.sample)
);
